// ===== hdl/sss_pkg.sv =====
// Shared definitions for the suffixient set scan unit.
// Holds the default sizes and configuration reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;
    localparam int ALPHABET_DEF      = 32;
    localparam int POSITION_BITS_DEF = 40;
    localparam int CFG_ADDR_BITS     = 4;
    localparam int CFG_DATA_BITS     = 64;
    localparam logic [5:0] ALPHABET_RESET = 6'd32;
    localparam logic [0:0] REG_ALPHABET = 1'b0;
    localparam logic [0:0] REG_TEXT_LEN = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/sss_table.sv =====
// Per-symbol candidate table: one synchronous memory with a registered read.
// Entries not written since reset read as the reset word. Uses sss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sss_table #(
    parameter int DEPTH = sss_pkg::ALPHABET_DEF,
    parameter int AW    = 5,
    parameter int W     = 8,
    parameter logic [W-1:0] RESET_WORD = '0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [W-1:0]  o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [W-1:0]  i_wr_data
);
    import sss_pkg::*;

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : RESET_WORD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd;
endmodule
`default_nettype wire

// ===== hdl/suffixient_set_scan_unit.sv =====
// Top level of the suffixient set scan unit: sequencer, registers and output stage.
// Depends on sss_pkg and sss_table.
//
// Items enter on the input channel in suffix-array order, one per entry, with
// valid and stall; results leave on the output channel the same way. An item
// that causes no run change and no closing flush is taken without leaving the
// idle state. A run change walks the candidate table from symbol 1 up to but
// not including the alphabet bound, each symbol by a memory read followed by
// an update and write back; it then refreshes the two bordering symbols, each
// by a read and, if the item's LCP exceeds the stored length, a write back; a
// final item adds a closing walk with the run minimum set to -1. The last
// result of an item is held back in a pending register so that it can be
// marked as last of run. While the receiver stalls, the walk waits at the
// next symbol that has a result to give and the input stays stalled. Reset
// (synchronous, active low) empties the table, clears the counters and
// restores the configuration registers (alphabet size 32, text length 2^40)
// at once; no clearing pass. The user writes configuration over the APB port
// only while no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module suffixient_set_scan_unit #(
    parameter int ALPHABET      = sss_pkg::ALPHABET_DEF,
    parameter int POSITION_BITS = sss_pkg::POSITION_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sss_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [sss_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic      [sss_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [POSITION_BITS-1:0]          i_lcp_value,
    input  wire logic [4:0]                        i_bwt_symbol,
    input  wire logic [POSITION_BITS-1:0]          i_suffix_position,
    input  wire logic                              i_first_item,
    input  wire logic                              i_final_item,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [POSITION_BITS-1:0]          o_entry_position,
    output logic      [POSITION_BITS:0]            o_lcs_length,
    output logic      [4:0]                        o_entry_symbol,
    output logic      [POSITION_BITS-1:0]          o_entry_number,
    output logic      [POSITION_BITS-1:0]          o_multiplicity,
    output logic                                   o_revise_valid,
    output logic      [POSITION_BITS-1:0]          o_revise_number,
    output logic      [POSITION_BITS:0]            o_revise_length,
    output logic                                   o_last_of_run
);
    import sss_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int L1 = POSITION_BITS + 1;
    localparam int AW = $clog2(ALPHABET);
    localparam int CW = $clog2(ALPHABET + 1);
    localparam int W  = 4 * L1 + 2 * P + 2;
    localparam logic [W-1:0] RESET_WORD = {{L1{1'b1}}, {L1{1'b0}}, {L1{1'b1}},
                                           {(P + P + L1 + 2){1'b0}}};
    localparam logic signed [L1-1:0] MIN_TOP = {1'b0, {P{1'b1}}};
    localparam logic signed [L1-1:0] MINUS_ONE = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_FRD, S_FEV, S_RRD, S_REV, S_DONE
    } t_state;

    typedef struct packed {
        logic [P-1:0]  position;
        logic [L1-1:0] lcs;
        logic [4:0]    symbol;
        logic [P-1:0]  number;
        logic [P-1:0]  mult;
        logic          rev_valid;
        logic [P-1:0]  rev_number;
        logic [L1-1:0] rev_length;
    } t_result;

    t_state                r_state;
    logic [5:0]            r_alph;
    logic [L1-1:0]         r_text_len;
    logic signed [L1-1:0]  r_rm;
    logic signed [L1-1:0]  r_m;
    logic [4:0]            r_prev_sym;
    logic [P-1:0]          r_prev_suf;
    logic [P-1:0]          r_total;
    logic [P-1:0]          r_lcp;
    logic [4:0]            r_sym;
    logic [P-1:0]          r_suf;
    logic                  r_fin;
    logic                  r_final_phase;
    logic                  r_second;
    logic [CW-1:0]         r_c;
    logic                  r_pend_v;
    t_result               r_pend;
    logic                  r_o_valid;
    t_result               r_out;
    logic                  r_out_last;

    logic [W-1:0]          rd_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [W-1:0]          wr_data;

    logic signed [L1-1:0]  d_len;
    logic [L1-1:0]         d_pos;
    logic signed [L1-1:0]  d_lcs;
    logic                  d_act;
    logic [P-1:0]          d_cnt;
    logic                  d_pv;
    logic [P-1:0]          d_pn;
    logic [L1-1:0]         d_pl;

    logic [6:0]            lim;
    logic                  walk_end;
    logic [4:0]            ref_sym;
    logic [P-1:0]          ref_suf;
    logic [AW+4:0]         ref_ext;
    logic                  ref_ok;
    logic signed [L1-1:0]  lcp_s;
    logic signed [L1-1:0]  in_lcp_s;
    logic signed [L1-1:0]  m_new;
    logic                  hit;
    logic                  emit;
    logic                  out_free;
    logic                  hold;
    logic                  out_load;
    logic                  ref_hit;
    logic [L1-1:0]         len_new;
    logic [P-1:0]          cnt_new;
    logic [L1-1:0]         pos_new;
    logic [L1-1:0]         pos_m1;
    logic [7:0]            c_ext;
    t_result               res;
    logic                  cfg_wr;

    assign {d_len, d_pos, d_lcs, d_act, d_cnt, d_pv, d_pn, d_pl} = rd_data;

    always_comb begin
        lim      = (7'(r_alph) > 7'(ALPHABET)) ? 7'(ALPHABET) : 7'(r_alph);
        walk_end = 7'(r_c) >= lim;
        ref_sym  = r_second ? r_sym : r_prev_sym;
        ref_suf  = r_second ? r_suf : r_prev_suf;
        ref_ext  = (AW + 5)'(ref_sym);
        ref_ok   = (ref_ext < (AW + 5)'(ALPHABET)) && ({1'b0, ref_sym} < r_alph);
        lcp_s    = $signed({1'b0, r_lcp});
        in_lcp_s = $signed({1'b0, i_lcp_value});
        m_new    = (in_lcp_s < r_rm) ? in_lcp_s : r_rm;
        hit      = r_m < d_len;
        emit     = hit && d_act;
        out_free = !r_o_valid || !i_stall;
        hold     = emit && r_pend_v && !out_free;
        out_load = ((r_state == S_FEV) && emit && r_pend_v && !hold)
                   || ((r_state == S_DONE) && r_pend_v && out_free);
        ref_hit  = lcp_s > d_len;
        len_new  = L1'(d_lcs + 1'b1);
        cnt_new  = d_cnt + 1'b1;
        pos_new  = r_text_len - {1'b0, ref_suf};
        pos_m1   = d_pos - 1'b1;
        c_ext    = 8'(r_c);

        res.position   = pos_m1[P-1:0];
        res.lcs        = len_new;
        res.symbol     = c_ext[4:0];
        res.number     = r_total;
        res.mult       = cnt_new;
        res.rev_valid  = d_pv;
        res.rev_number = d_pv ? d_pn : '0;
        res.rev_length = d_pv ? ((d_pl > len_new) ? d_pl : len_new) : '0;

        rd_en   = 1'b0;
        rd_addr = ref_ext[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_c[AW-1:0];
        wr_data = {r_m, {L1{1'b0}}, r_m, 1'b0,
                   emit ? cnt_new : d_cnt,
                   emit ? 1'b1 : d_pv,
                   emit ? r_total : d_pn,
                   emit ? len_new : d_pl};
        case (r_state)
            S_FRD: begin
                rd_en   = !walk_end;
                rd_addr = r_c[AW-1:0];
            end
            S_FEV: begin
                wr_en = hit && !hold;
            end
            S_RRD: begin
                rd_en = ref_ok;
            end
            S_REV: begin
                wr_en   = ref_hit;
                wr_addr = ref_ext[AW-1:0];
                wr_data = {lcp_s, pos_new, d_lcs, 1'b1, d_cnt, d_pv, d_pn, d_pl};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    sss_table #(
        .DEPTH      (ALPHABET),
        .AW         (AW),
        .W          (W),
        .RESET_WORD (RESET_WORD)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alph     <= ALPHABET_RESET;
            r_text_len <= {1'b1, {P{1'b0}}};
        end else if (cfg_wr) begin
            if (paddr[3] == REG_TEXT_LEN) begin
                r_text_len <= pwdata[L1-1:0];
            end else begin
                r_alph <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        prdata = (paddr[3] == REG_ALPHABET) ? CFG_DATA_BITS'(r_alph)
                                            : CFG_DATA_BITS'(r_text_len);
        pready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rm          <= MIN_TOP;
            r_prev_sym    <= '0;
            r_prev_suf    <= '0;
            r_total       <= '0;
            r_pend_v      <= 1'b0;
            r_o_valid     <= 1'b0;
            r_final_phase <= 1'b0;
            r_second      <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_lcp <= i_lcp_value;
                        r_sym <= i_bwt_symbol;
                        r_suf <= i_suffix_position;
                        r_fin <= i_final_item;
                        r_c   <= CW'(1);
                        if (!i_first_item && (i_bwt_symbol != r_prev_sym)) begin
                            r_m           <= m_new;
                            r_rm          <= MIN_TOP;
                            r_final_phase <= 1'b0;
                            r_second      <= 1'b0;
                            r_state       <= S_FRD;
                        end else begin
                            if (!i_first_item) begin
                                r_rm <= m_new;
                            end
                            r_prev_sym <= i_bwt_symbol;
                            r_prev_suf <= i_suffix_position;
                            if (i_final_item) begin
                                r_m           <= MINUS_ONE;
                                r_final_phase <= 1'b1;
                                r_state       <= S_FRD;
                            end
                        end
                    end
                end
                S_FRD: begin
                    if (walk_end) begin
                        r_state <= r_final_phase ? S_DONE : S_RRD;
                    end else begin
                        r_state <= S_FEV;
                    end
                end
                S_FEV: begin
                    if (!hold) begin
                        if (emit) begin
                            r_pend   <= res;
                            r_pend_v <= 1'b1;
                            r_total  <= r_total + 1'b1;
                            if (r_pend_v) begin
                                r_out      <= r_pend;
                                r_out_last <= 1'b0;
                            end
                        end
                        r_c     <= r_c + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_RRD: begin
                    if (ref_ok) begin
                        r_state <= S_REV;
                    end else if (!r_second) begin
                        r_second <= 1'b1;
                    end else begin
                        r_prev_sym <= r_sym;
                        r_prev_suf <= r_suf;
                        r_second   <= 1'b0;
                        r_c        <= CW'(1);
                        if (r_fin) begin
                            r_m           <= MINUS_ONE;
                            r_final_phase <= 1'b1;
                            r_state       <= S_FRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_REV: begin
                    if (!r_second) begin
                        r_second <= 1'b1;
                        r_state  <= S_RRD;
                    end else begin
                        r_prev_sym <= r_sym;
                        r_prev_suf <= r_suf;
                        r_second   <= 1'b0;
                        r_c        <= CW'(1);
                        if (r_fin) begin
                            r_m           <= MINUS_ONE;
                            r_final_phase <= 1'b1;
                            r_state       <= S_FRD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out      <= r_pend;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_stall          = (r_state != S_IDLE);
        o_valid          = r_o_valid;
        o_entry_position = r_out.position;
        o_lcs_length     = r_out.lcs;
        o_entry_symbol   = r_out.symbol;
        o_entry_number   = r_out.number;
        o_multiplicity   = r_out.mult;
        o_revise_valid   = r_out.rev_valid;
        o_revise_number  = r_out.rev_number;
        o_revise_length  = r_out.rev_length;
        o_last_of_run    = r_out_last;
    end
endmodule
`default_nettype wire

// ===== dv/tb_suffixient_set_scan_unit.sv =====
// Self-checking testbench for the suffixient set scan unit, driven through both handshakes.
// A directed table and random suffix-array scans are checked against an in-bench predictor.
// Depends on sss_pkg and suffixient_set_scan_unit.
`timescale 1ns / 1ps
module tb_suffixient_set_scan_unit;
    import sss_pkg::*;

    localparam int PB = POSITION_BITS_DEF;
    localparam int NSYM = ALPHABET_DEF;
    localparam longint MIN_TOP = (64'd1 << PB) - 1;

    typedef struct {
        bit [PB-1:0] pos;
        bit [PB:0]   lcs;
        bit [4:0]    sym;
        bit [PB-1:0] num;
        bit [PB-1:0] mult;
        bit          rv;
        bit [PB-1:0] rnum;
        bit [PB:0]   rlen;
        bit          last;
    } t_entry;

    typedef struct {
        bit [PB-1:0] lcp;
        bit [4:0]    sym;
        bit [PB-1:0] suf;
        bit          first;
        bit          fin;
        int          nres;
    } t_row;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata, prdata;
    logic pready;
    logic i_valid, o_stall, i_first_item, i_final_item;
    logic [PB-1:0] i_lcp_value, i_suffix_position;
    logic [4:0] i_bwt_symbol;
    logic o_valid, i_stall;
    logic [PB-1:0] o_entry_position, o_entry_number, o_multiplicity, o_revise_number;
    logic [PB:0] o_lcs_length, o_revise_length;
    logic [4:0] o_entry_symbol;
    logic o_revise_valid, o_last_of_run;

    suffixient_set_scan_unit uut (.*);

    longint      cand_len[NSYM];
    longint      cand_lcs[NSYM];
    bit [PB:0]   cand_pos[NSYM];
    bit          cand_act[NSYM];
    bit [PB-1:0] sym_count[NSYM];
    bit          prior_ok[NSYM];
    bit [PB-1:0] prior_num[NSYM];
    bit [PB:0]   prior_len[NSYM];
    longint      run_min;
    bit [4:0]    prev_sym;
    bit [PB-1:0] prev_suf;
    bit [PB-1:0] entry_total;
    bit [5:0]    alpha_reg;
    bit [PB:0]   tlen_reg;

    t_entry entry_q[$];
    int     mismatches;
    int     hold_seq;
    int     burst_left;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int flush_cands(longint m, int k);
        int lim;
        t_entry e;
        bit [PB:0] len;
        lim = alpha_reg > NSYM ? NSYM : alpha_reg;
        for (int c = 1; c < lim; c++) begin
            if (!(m < cand_len[c])) continue;
            if (cand_act[c] && k < 33) begin
                len = (PB+1)'(cand_lcs[c] + 1);
                sym_count[c] = sym_count[c] + 1;
                e.pos = PB'(cand_pos[c] - 1);
                e.lcs = len;
                e.sym = 5'(c);
                e.num = entry_total;
                e.mult = sym_count[c];
                e.rv = prior_ok[c];
                e.rnum = prior_ok[c] ? prior_num[c] : '0;
                e.rlen = prior_ok[c] ? (prior_len[c] > len ? prior_len[c] : len) : '0;
                e.last = 0;
                entry_q = {entry_q, e};
                prior_ok[c] = 1;
                prior_num[c] = entry_total;
                prior_len[c] = len;
                entry_total = entry_total + 1;
                k++;
            end
            cand_len[c] = m;
            cand_pos[c] = '0;
            cand_lcs[c] = m;
            cand_act[c] = 0;
        end
        return k;
    endfunction

    function automatic void refresh_cand(bit [4:0] s, bit [PB-1:0] suf, longint lcp);
        if (s >= NSYM || s >= alpha_reg) return;
        if (lcp > cand_len[s]) begin
            cand_len[s] = lcp;
            cand_pos[s] = tlen_reg - suf;
            cand_act[s] = 1;
        end
    endfunction

    // Returns the number of entries the item emits.
    function automatic int predict_entries(t_row r);
        int k;
        longint lcp;
        k = 0;
        lcp = longint'(r.lcp);
        if (!r.first) begin
            if (lcp < run_min) run_min = lcp;
            if (r.sym != prev_sym) begin
                k = flush_cands(run_min, k);
                refresh_cand(prev_sym, prev_suf, lcp);
                refresh_cand(r.sym, r.suf, lcp);
                run_min = MIN_TOP;
            end
        end
        prev_sym = r.sym;
        prev_suf = r.suf;
        if (r.fin) k = flush_cands(-1, k);
        if (k > 0) entry_q[$].last = 1;
        return k;
    endfunction

    always @(posedge i_clk) begin
        t_entry e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (entry_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected entry, symbol %0d", o_entry_symbol);
            end else begin
                e = entry_q.pop_front();
                if (o_entry_position !== e.pos || o_lcs_length !== e.lcs
                        || o_entry_symbol !== e.sym || o_entry_number !== e.num
                        || o_multiplicity !== e.mult || o_revise_valid !== e.rv
                        || o_revise_number !== e.rnum || o_revise_length !== e.rlen
                        || o_last_of_run !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %0d %h %h %b %h %h %b got %h %h %0d %h %h %b %h %h %b",
                                 e.pos, e.lcs, e.sym, e.num, e.mult, e.rv, e.rnum, e.rlen, e.last,
                                 o_entry_position, o_lcs_length, o_entry_symbol, o_entry_number,
                                 o_multiplicity, o_revise_valid, o_revise_number,
                                 o_revise_length, o_last_of_run);
                end
            end
        end
    end

    // The receiver stalls on a changing pattern, with one long hold on request.
    initial begin
        int seen, hold_left, mode, mode_left;
        seen = 0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen) begin
                seen = hold_seq;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1;
            end else if (mode == 0)
                i_stall <= 0;
            else if (mode == 1)
                i_stall <= ($urandom_range(0, 1) == 1);
            else
                i_stall <= ($urandom_range(0, 9) != 0);
        end
    end

    task automatic send_item(t_row r);
        int gap, k;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1;
        i_lcp_value <= r.lcp;
        i_bwt_symbol <= r.sym;
        i_suffix_position <= r.suf;
        i_first_item <= r.first;
        i_final_item <= r.fin;
        do @(posedge i_clk); while (o_stall);
        k = predict_entries(r);
        if (r.nres >= 0 && k != r.nres) begin
            mismatches++;
            if (mismatches <= 10) $display("entry count: exp %0d predicted %0d", r.nres, k);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        while (entry_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= CFG_ADDR_BITS'(idx) << 3;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_ALPHABET) alpha_reg = val[5:0];
        else tlen_reg = val[PB:0];
    endtask

    function automatic bit [PB-1:0] rand_wide();
        return PB'({$urandom, $urandom});
    endfunction

    task automatic run_scan(int n);
        t_row r;
        int sym_hi;
        bit noisy;
        sym_hi = alpha_reg > NSYM ? NSYM - 1 : (alpha_reg == 0 ? 1 : alpha_reg);
        if (sym_hi > 31) sym_hi = 31;
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++) begin
            r.lcp = ($urandom_range(0, 15) == 0) ? rand_wide() : PB'($urandom_range(0, 8));
            r.sym = ($urandom_range(0, 2) == 0) ? prev_sym : 5'($urandom_range(0, sym_hi));
            r.suf = rand_wide();
            if (tlen_reg != 0 && $urandom_range(0, 9) != 0) r.suf = r.suf % tlen_reg;
            r.first = (i == 0);
            r.fin = (i == n - 1);
            if (noisy) begin
                r.first = $urandom_range(0, 5) == 0;
                r.fin = $urandom_range(0, 5) == 0;
            end
            r.nres = -1;
            send_item(r);
        end
    endtask

    t_row directed[] = '{
        '{40'd0, 5'd3, 40'd10, 1'b1, 1'b0, 0},
        '{40'd0, 5'd3, 40'd11, 1'b0, 1'b0, 0},
        '{40'd2, 5'd5, 40'd12, 1'b0, 1'b0, 0},
        '{40'd1, 5'd31, 40'd13, 1'b0, 1'b0, 2},
        '{40'hFF_FFFF_FFFF, 5'd0, 40'hFF_FFFF_FFFF, 1'b0, 1'b0, -1},
        '{40'd0, 5'd0, 40'd0, 1'b0, 1'b1, -1},
        '{40'd4, 5'd7, 40'd3, 1'b1, 1'b1, -1},
        '{40'd3, 5'd9, 40'd5, 1'b0, 1'b0, -1},
        '{40'd3, 5'd7, 40'd6, 1'b0, 1'b0, -1},
        '{40'd1, 5'd9, 40'd8, 1'b0, 1'b0, -1},
        '{40'd5, 5'd16, 40'h80_0000_0000, 1'b0, 1'b0, -1},
        '{40'd2, 5'd9, 40'd2, 1'b0, 1'b0, -1},
        '{40'd6, 5'd16, 40'd1, 1'b0, 1'b1, -1}
    };

    initial begin
        i_rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        i_valid = 0;
        i_lcp_value = '0;
        i_bwt_symbol = '0;
        i_suffix_position = '0;
        i_first_item = 0;
        i_final_item = 0;
        mismatches = 0;
        hold_seq = 0;
        burst_left = 0;
        for (int c = 0; c < NSYM; c++) begin
            cand_len[c] = -1;
            cand_lcs[c] = -1;
            cand_pos[c] = '0;
            cand_act[c] = 0;
            sym_count[c] = '0;
            prior_ok[c] = 0;
            prior_num[c] = '0;
            prior_len[c] = '0;
        end
        run_min = MIN_TOP;
        prev_sym = '0;
        prev_suf = '0;
        entry_total = '0;
        alpha_reg = ALPHABET_RESET;
        tlen_reg = 41'd1 << PB;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        foreach (directed[i]) send_item(directed[i]);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                0: begin write_reg(REG_ALPHABET, 64'd2); write_reg(REG_TEXT_LEN, 64'd2); end
                1: begin write_reg(REG_ALPHABET, 64'd63); write_reg(REG_TEXT_LEN, 64'd1 << PB); end
                2: begin write_reg(REG_ALPHABET, 64'd0); write_reg(REG_TEXT_LEN, 64'd1000); end
                3: write_reg(REG_ALPHABET, 64'd1);
                4: begin write_reg(REG_ALPHABET, 64'd32); write_reg(REG_TEXT_LEN, rand_wide()); end
                5: write_reg(REG_ALPHABET, 64'($urandom_range(3, 31)));
                6: begin write_reg(REG_ALPHABET, 64'd17); write_reg(REG_TEXT_LEN, 64'd50); end
                default: begin
                    write_reg(REG_ALPHABET, 64'd32);
                    write_reg(REG_TEXT_LEN, {23'd0, 1'b1, rand_wide()});
                end
            endcase
            if (ph == 4) hold_seq++;
            for (int t = 0; t < 6; t++) run_scan($urandom_range(2, 14));
        end

        wait_idle();
        if (mismatches == 0 && entry_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/sss_pkg.sv
hdl/sss_table.sv
hdl/suffixient_set_scan_unit.sv
dv/tb_suffixient_set_scan_unit.sv
